// ===== design/cic_pkg.sv =====
package cic_pkg;

    localparam int unsigned FORM_W = 40;
    localparam int unsigned LEN_W  = 3;

    // Request kinds.
    typedef enum logic
    {
        KIND_ENCODE = 1'b0,
        KIND_DECODE = 1'b1
    } cic_kind_t;

    // Form lengths in bytes.
    localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;
    localparam logic [LEN_W-1:0] LEN_FIVE = 3'd5;

    // Magnitude limits of the short forms.
    localparam logic [31:0] U_LIM1 = 32'h0000_0080;
    localparam logic [31:0] U_LIM2 = 32'h0000_4000;
    localparam logic [31:0] U_LIM4 = 32'h2000_0000;
    localparam logic [31:0] S_LIM1 = 32'h0000_0040;
    localparam logic [31:0] S_LIM2 = 32'h0000_2000;
    localparam logic [31:0] S_LIM4 = 32'h1000_0000;

    // Prefixes for non-negative and negative forms.
    localparam logic [7:0]  POS_P1 = 8'h00;
    localparam logic [7:0]  NEG_P1 = 8'h40;
    localparam logic [15:0] POS_P2 = 16'h8000;
    localparam logic [15:0] NEG_P2 = 16'ha000;
    localparam logic [31:0] POS_P4 = 32'hc000_0000;
    localparam logic [31:0] NEG_P4 = 32'hd000_0000;
    localparam logic [7:0]  POS_P5 = 8'he0;
    localparam logic [7:0]  NEG_P5 = 8'hf0;

    typedef struct packed {
        logic [FORM_W-1:0] form;   // first byte in the top bits
        logic [LEN_W-1:0]  len;
    } cic_enc_t;

    typedef struct packed {
        logic        produce;      // this byte completes a value
        logic [31:0] value;
    } cic_dec_t;

endpackage

// ===== design/cic_in_if.sv =====
interface cic_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] value;
    logic [7:0]  in_byte;

    modport source (output valid, output kind, output value, output in_byte, input ready);
    modport sink   (input valid, input kind, input value, input in_byte, output ready);
endinterface

// ===== design/cic_out_if.sv =====
interface cic_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [31:0] decoded_value;
    logic        value_valid;

    modport source (output valid, output out_byte, output byte_valid, output last,
                    output decoded_value, output value_valid, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input last,
                    input decoded_value, input value_valid, output ready);
endinterface

// ===== design/cic_encoder.sv =====
module cic_encoder (
    input  logic             signed_mode,
    input  logic [31:0]      value,
    output cic_pkg::cic_enc_t enc
);
    import cic_pkg::*;

    logic        neg;
    logic [31:0] mag;
    logic [31:0] lim1;
    logic [31:0] lim2;
    logic [31:0] lim4;
    logic [7:0]  p1;
    logic [15:0] p2;
    logic [31:0] p4;
    logic [7:0]  p5;

    assign neg  = signed_mode & value[31];
    assign mag  = neg ? (32'd0 - value) : value;
    assign lim1 = signed_mode ? S_LIM1 : U_LIM1;
    assign lim2 = signed_mode ? S_LIM2 : U_LIM2;
    assign lim4 = signed_mode ? S_LIM4 : U_LIM4;
    assign p1   = neg ? NEG_P1 : POS_P1;
    assign p2   = neg ? NEG_P2 : POS_P2;
    assign p4   = neg ? NEG_P4 : POS_P4;
    assign p5   = neg ? NEG_P5 : POS_P5;

    always_comb
    begin
        if (mag < lim1)
        begin
            enc.form = {mag[7:0] | p1, 32'd0};
            enc.len  = LEN_ONE;
        end
        else if (mag < lim2)
        begin
            enc.form = {mag[15:0] | p2, 24'd0};
            enc.len  = LEN_TWO;
        end
        else if (mag < lim4)
        begin
            enc.form = {mag | p4, 8'd0};
            enc.len  = LEN_FOUR;
        end
        else
        begin
            enc.form = {p5, mag};
            enc.len  = LEN_FIVE;
        end
    end

endmodule

// ===== design/cic_decoder.sv =====
module cic_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              signed_mode,
    input  logic              step,
    input  logic [7:0]        in_byte,
    output cic_pkg::cic_dec_t dec
);
    import cic_pkg::*;

    localparam logic [2:0] MASK_NONE = 3'd0;
    localparam logic [2:0] MASK_8000 = 3'd1;
    localparam logic [2:0] MASK_A000 = 3'd2;
    localparam logic [2:0] MASK_C000 = 3'd3;
    localparam logic [2:0] MASK_D000 = 3'd4;

    logic [2:0]  bytes_left_reg, bytes_left_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  mask_kind_reg, mask_kind_next;
    logic        negate_reg, negate_next;
    logic [31:0] mask;
    logic [31:0] acc_shift;
    logic [31:0] cleared;
    logic [31:0] lead;

    assign acc_shift = {acc_reg[23:0], in_byte};
    assign lead      = {24'd0, in_byte};

    always_comb
    begin
        case (mask_kind_reg)
            MASK_8000: mask = 32'h0000_8000;
            MASK_A000: mask = 32'h0000_a000;
            MASK_C000: mask = 32'hc000_0000;
            MASK_D000: mask = 32'hd000_0000;
            default:   mask = 32'd0;
        endcase
    end

    assign cleared = acc_shift & ~mask;

    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        mask_kind_next  = mask_kind_reg;
        negate_next     = negate_reg;
        dec.produce     = 1'b0;
        dec.value       = lead;
        if (bytes_left_reg != 3'd0)
        begin
            acc_next        = acc_shift;
            bytes_left_next = bytes_left_reg - 3'd1;
            if (bytes_left_reg == 3'd1)
            begin
                dec.produce    = 1'b1;
                dec.value      = negate_reg ? (32'd0 - cleared) : cleared;
                mask_kind_next = MASK_NONE;
                negate_next    = 1'b0;
            end
        end
        else if (signed_mode)
        begin
            case (in_byte[7:4])
                4'hf:
                begin
                    acc_next = 32'd0; bytes_left_next = 3'd4;
                    mask_kind_next = MASK_NONE; negate_next = 1'b1;
                end
                4'he:
                begin
                    acc_next = 32'd0; bytes_left_next = 3'd4;
                    mask_kind_next = MASK_NONE; negate_next = 1'b0;
                end
                4'hd:
                begin
                    acc_next = lead; bytes_left_next = 3'd3;
                    mask_kind_next = MASK_D000; negate_next = 1'b1;
                end
                4'hc:
                begin
                    acc_next = lead; bytes_left_next = 3'd3;
                    mask_kind_next = MASK_C000; negate_next = 1'b0;
                end
                4'hb, 4'ha:
                begin
                    acc_next = lead; bytes_left_next = 3'd1;
                    mask_kind_next = MASK_A000; negate_next = 1'b1;
                end
                4'h9, 4'h8:
                begin
                    acc_next = lead; bytes_left_next = 3'd1;
                    mask_kind_next = MASK_8000; negate_next = 1'b0;
                end
                4'h7, 4'h6, 4'h5, 4'h4:
                begin
                    dec.produce = 1'b1;
                    dec.value   = 32'd0 - {26'd0, in_byte[5:0]};
                end
                default:
                begin
                    dec.produce = 1'b1;
                end
            endcase
        end
        else
        begin
            case (in_byte[7:5])
                3'h7:
                begin
                    acc_next = 32'd0; bytes_left_next = 3'd4;
                    mask_kind_next = MASK_NONE; negate_next = 1'b0;
                end
                3'h6:
                begin
                    acc_next = lead; bytes_left_next = 3'd3;
                    mask_kind_next = MASK_C000; negate_next = 1'b0;
                end
                3'h5, 3'h4:
                begin
                    acc_next = lead; bytes_left_next = 3'd1;
                    mask_kind_next = MASK_8000; negate_next = 1'b0;
                end
                default:
                begin
                    dec.produce = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 3'd0;
            acc_reg        <= 32'd0;
            mask_kind_reg  <= MASK_NONE;
            negate_reg     <= 1'b0;
        end
        else if (step)
        begin
            bytes_left_reg <= bytes_left_next;
            acc_reg        <= acc_next;
            mask_kind_reg  <= mask_kind_next;
            negate_reg     <= negate_next;
        end
    end

    // A pending form is never longer than four further bytes.
    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_left_reg <= 3'd4)
        else $error("decoder byte count out of range");

    // Only the last byte of a form, or a one-byte form, completes a value.
    a_produce_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step && dec.produce) |=> (bytes_left_reg == 3'd0 && mask_kind_reg == MASK_NONE))
        else $error("decoder finished a value with a form still open");

endmodule

// ===== design/compact_int32_codec_unit.sv =====
// Channel | Modport           | Payload
// in_ch   | cic_in_if.sink    | kind, value, in_byte
// out_ch  | cic_out_if.source | out_byte, byte_valid, last, decoded_value, value_valid
// cfg     | cfg_we/cfg_wdata  | signed_mode, written on any edge with cfg_we high
//
// A decode request gives at most one result.
// An encode request holds the request register for 1, 2, 4 or 5 form bytes, one byte per
// cycle into the result register while it is free; the byte index counter tracks them.
// Requests are taken while a result waits, as long as the request register drains.
// A stalled result holds any request that must write it; rst_n clears all control state.
module compact_int32_codec_unit (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_we,
    input  logic  cfg_wdata,
    cic_in_if.sink    in_ch,
    cic_out_if.source out_ch
);
    import cic_pkg::*;

    logic        signed_mode_reg;
    logic        in_valid_reg;
    logic        kind_reg;
    logic [31:0] value_reg;
    logic [7:0]  byte_reg;
    logic [2:0]  idx_reg, idx_next;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        byte_valid_reg;
    logic        last_reg;
    logic [31:0] dec_value_reg;
    logic        value_valid_reg;

    cic_enc_t    enc;
    cic_dec_t    dec;
    logic        out_free;
    logic        emit;
    logic        enc_last;
    logic        dec_step;
    logic        retire;
    logic [7:0]  cur_byte;

    cic_encoder u_enc (
        .signed_mode (signed_mode_reg),
        .value       (value_reg),
        .enc         (enc)
    );

    cic_decoder u_dec (
        .clk         (clk),
        .rst_n       (rst_n),
        .signed_mode (signed_mode_reg),
        .step        (dec_step),
        .in_byte     (byte_reg),
        .dec         (dec)
    );

    always_comb
    begin
        case (idx_reg)
            3'd0:    cur_byte = enc.form[39:32];
            3'd1:    cur_byte = enc.form[31:24];
            3'd2:    cur_byte = enc.form[23:16];
            3'd3:    cur_byte = enc.form[15:8];
            3'd4:    cur_byte = enc.form[7:0];
            default: cur_byte = 8'd0;
        endcase
    end

    assign out_free = !out_valid_reg || out_ch.ready;
    assign enc_last = (idx_reg == (enc.len - 3'd1));
    assign emit     = in_valid_reg && (kind_reg == KIND_ENCODE) && out_free;
    // A decode byte that completes nothing leaves without needing the result register.
    assign dec_step = in_valid_reg && (kind_reg == KIND_DECODE) && (out_free || !dec.produce);
    assign retire   = (emit && enc_last) || dec_step;
    assign idx_next = retire ? 3'd0 : (emit ? idx_reg + 3'd1 : idx_reg);

    assign in_ch.ready = !in_valid_reg || retire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b0;
            in_valid_reg    <= 1'b0;
            idx_reg         <= 3'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                signed_mode_reg <= cfg_wdata;
            if (in_ch.ready)
                in_valid_reg <= in_ch.valid;
            idx_reg <= idx_next;
            if (out_free)
                out_valid_reg <= emit || (dec_step && dec.produce);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            kind_reg  <= in_ch.kind;
            value_reg <= in_ch.value;
            byte_reg  <= in_ch.in_byte;
        end
        if (emit)
        begin
            out_byte_reg    <= cur_byte;
            byte_valid_reg  <= 1'b1;
            last_reg        <= enc_last;
            dec_value_reg   <= 32'd0;
            value_valid_reg <= 1'b0;
        end
        else if (dec_step && dec.produce)
        begin
            out_byte_reg    <= 8'd0;
            byte_valid_reg  <= 1'b0;
            last_reg        <= 1'b0;
            dec_value_reg   <= dec.value;
            value_valid_reg <= 1'b1;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_byte      = out_byte_reg;
    assign out_ch.byte_valid    = byte_valid_reg;
    assign out_ch.last          = last_reg;
    assign out_ch.decoded_value = dec_value_reg;
    assign out_ch.value_valid   = value_valid_reg;

    // Every result is either an encoded byte or a decoded value, never both.
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (byte_valid_reg ^ value_valid_reg))
        else $error("result carries both or neither kind");

    // The byte index only moves while an encode request is held.
    a_idx_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 3'd0) |-> (in_valid_reg && kind_reg == KIND_ENCODE))
        else $error("byte index set without an encode request");

    // No form is longer than five bytes.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= 3'd4)
        else $error("byte index out of range");

    // A decoded value never carries the last flag.
    a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> byte_valid_reg)
        else $error("last flag on a decode result");

endmodule
